/* design/ttm_pkg.sv */
// Shared types and constants for the touch event tap mapper.
// No dependencies; imported by every design module and the checker.
package ttm_pkg;

  localparam logic [15:0] EVT_SYN = 16'd0;
  localparam logic [15:0] EVT_KEY = 16'd1;
  localparam logic [15:0] EVT_ABS = 16'd3;

  localparam logic [15:0] CODE_SYN_REPORT     = 16'd0;
  localparam logic [15:0] CODE_KEY_POWER      = 16'd116;
  localparam logic [15:0] CODE_BTN_TOOL_PEN   = 16'd320;
  localparam logic [15:0] CODE_BTN_TOOL_FINGER = 16'd325;
  localparam logic [15:0] CODE_BTN_TOUCH      = 16'd330;
  localparam logic [15:0] CODE_ABS_X          = 16'd0;
  localparam logic [15:0] CODE_ABS_Y          = 16'd1;
  localparam logic [15:0] CODE_MT_X           = 16'd53;
  localparam logic [15:0] CODE_MT_Y           = 16'd54;
  localparam logic [15:0] CODE_MT_TRACK       = 16'd57;

  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_ORIENT        = 3'd2;
  localparam logic [2:0] CFG_X_MIN         = 3'd3;
  localparam logic [2:0] CFG_X_MAX         = 3'd4;
  localparam logic [2:0] CFG_Y_MIN         = 3'd5;
  localparam logic [2:0] CFG_Y_MAX         = 3'd6;

  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_REARM = 1'b1;

  localparam logic KIND_TAP  = 1'b0;
  localparam logic KIND_EXIT = 1'b1;

  localparam logic [12:0] MIN_DIM      = 13'd1;
  localparam logic [12:0] MAX_DIM      = 13'd4096;
  localparam logic [13:0] SCALE_MARGIN = 14'd64;
  localparam logic [15:0] KEY_DOWN     = 16'd1;

  localparam int unsigned QUO_W   = 12;
  localparam int unsigned DEN_W   = 32;
  localparam int unsigned NUM_W   = DEN_W + QUO_W;
  localparam logic [3:0]  DIV_STEPS = 4'(QUO_W);

  typedef struct packed {
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
    logic [2:0]         orient;
    logic signed [31:0] x_min;
    logic signed [31:0] x_max;
    logic signed [31:0] y_min;
    logic signed [31:0] y_max;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic        done;
    logic [11:0] x;
    logic [11:0] y;
  } map_rsp_t;

  function automatic logic [12:0] clamp_dim(input logic [12:0] d);
    logic [12:0] r;
    if (d < MIN_DIM) begin
      r = MIN_DIM;
    end else if (d > MAX_DIM) begin
      r = MAX_DIM;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

/* design/ttm_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on ttm_pkg; used by ttm_mapper for both axes.
module ttm_divider import ttm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] nlo_r, nlo_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // quotient is known to fit QUO_W bits, so the top numerator bits start as remainder
  assign trial = {rem_r, nlo_r[QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    nlo_nxt  = nlo_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.num[NUM_W-1:QUO_W];
      nlo_nxt  = req.num[QUO_W-1:0];
      den_nxt  = req.den;
      cnt_nxt  = DIV_STEPS;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      nlo_nxt = {nlo_r[QUO_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    nlo_r <= nlo_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

/* design/ttm_mapper.sv */
// Point mapping sequencer: range test, per-axis scale through the shared
// divider, then mirror and clamp. Depends on ttm_pkg and ttm_divider.
module ttm_mapper import ttm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  cfg_t               cfg,
  input  logic signed [31:0] raw_x,
  input  logic signed [31:0] raw_y,
  output map_rsp_t           rsp
);

  typedef enum logic [4:0] {
    M_IDLE  = 5'b00001,
    M_SPAN  = 5'b00010,
    M_SETUP = 5'b00100,
    M_MULT  = 5'b01000,
    M_DIV   = 5'b10000
  } mstate_t;

  mstate_t            state_r, state_nxt;
  logic               axis_r, axis_nxt;
  logic               cond_r, cond_nxt;
  logic signed [31:0] v_r, v_nxt;
  logic signed [32:0] d_r, d_nxt;
  logic signed [32:0] span_r, span_nxt;
  logic               scl_r, scl_nxt;
  logic               lo_r, lo_nxt;
  logic               hi_r, hi_nxt;
  logic [11:0]        x_r, x_nxt;
  logic [11:0]        y_r, y_nxt;
  logic               done_r, done_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [12:0]        sw, sh;
  logic [11:0]        w, h, top;
  logic [13:0]        longest;
  logic signed [32:0] span_x, span_y, lim;
  logic               use_y, mir;
  logic signed [31:0] sel_v, sel_lo, sel_hi;
  logic [11:0]        sc, res;
  logic signed [33:0] val, mval, top_s;

  assign sw      = clamp_dim(cfg.screen_width);
  assign sh      = clamp_dim(cfg.screen_height);
  assign w       = 12'(sw - 13'd1);
  assign h       = 12'(sh - 13'd1);
  assign longest = ((sw > sh) ? {1'b0, sw} : {1'b0, sh}) + SCALE_MARGIN;
  assign lim     = $signed({19'd0, longest});
  assign span_x  = {cfg.x_max[31], cfg.x_max} - {cfg.x_min[31], cfg.x_min};
  assign span_y  = {cfg.y_max[31], cfg.y_max} - {cfg.y_min[31], cfg.y_min};

  // output axis 0 is x, 1 is y; swap picks the other raw source
  assign use_y  = cfg.orient[0] ^ axis_r;
  assign sel_v  = use_y ? raw_y : raw_x;
  assign sel_lo = use_y ? cfg.y_min : cfg.x_min;
  assign sel_hi = use_y ? cfg.y_max : cfg.x_max;
  assign top    = axis_r ? h : w;
  assign mir    = axis_r ? cfg.orient[2] : cfg.orient[1];
  assign top_s  = $signed({22'd0, top});

  assign div_req.start = (state_r == M_MULT);
  assign div_req.num   = NUM_W'(d_r[31:0]) * NUM_W'(top);
  assign div_req.den   = span_r[31:0];

  assign sc   = lo_r ? 12'd0 : (hi_r ? top : div_rsp.quo);
  assign val  = scl_r ? $signed({22'd0, sc}) : $signed({{2{v_r[31]}}, v_r});
  assign mval = mir ? (top_s - val) : val;
  assign res  = mval[33] ? 12'd0 : ((mval > top_s) ? top : mval[11:0]);

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cond_nxt  = cond_r;
    v_nxt     = v_r;
    d_nxt     = d_r;
    span_nxt  = span_r;
    scl_nxt   = scl_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      M_IDLE: begin
        if (start) begin
          state_nxt = M_SPAN;
        end
      end
      M_SPAN: begin
        cond_nxt  = (span_x > lim) || (span_y > lim);
        axis_nxt  = 1'b0;
        state_nxt = M_SETUP;
      end
      M_SETUP: begin
        v_nxt     = sel_v;
        d_nxt     = {sel_v[31], sel_v} - {sel_lo[31], sel_lo};
        span_nxt  = {sel_hi[31], sel_hi} - {sel_lo[31], sel_lo};
        scl_nxt   = cond_r && (sel_hi > sel_lo);
        state_nxt = M_MULT;
      end
      M_MULT: begin
        lo_nxt    = d_r[32] || (d_r == '0);
        hi_nxt    = (d_r >= span_r);
        state_nxt = M_DIV;
      end
      M_DIV: begin
        if (div_rsp.done) begin
          if (!axis_r) begin
            x_nxt     = res;
            axis_nxt  = 1'b1;
            state_nxt = M_SETUP;
          end else begin
            y_nxt     = res;
            done_nxt  = 1'b1;
            state_nxt = M_IDLE;
          end
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cond_r <= cond_nxt;
    v_r    <= v_nxt;
    d_r    <= d_nxt;
    span_r <= span_nxt;
    scl_r  <= scl_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    if (!rst_n) begin
      state_r <= M_IDLE;
      axis_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      done_r  <= done_nxt;
    end
  end

  ttm_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign rsp.done = done_r;
  assign rsp.x    = x_r;
  assign rsp.y    = y_r;

endmodule

/* design/touch_event_tap_mapper.sv */
// Top level: stream ports, configuration registers, event decode and touch state.
// Depends on ttm_pkg and ttm_mapper.
//
// Turns Linux input events into screen taps and exit-key presses. A beat that yields
// no result leaves the block ready for the next beat; a beat that yields a result is
// moved, in T_HOLD, into the output register once that register is free or draining,
// and the register holds it while the next beats are accepted. A sync report that
// fires a tap first occupies the block in T_MAP while the shared 12-step serial
// divider scales the two axes one after the other. Configuration writes are always ready.
module touch_event_tap_mapper import ttm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // ev_type[15:0], ev_code[31:16], ev_value[63:32]
  input  logic [1:0]  in_tuser,   // req_type[0], from_touch[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // tap_x[11:0], tap_y[23:12]
  output logic        out_tuser,  // result_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_MAP  = 3'b010,
    T_HOLD = 3'b100
  } tstate_t;

  tstate_t            state_r, state_nxt;
  cfg_t               cfg_r, cfg_nxt;
  logic signed [31:0] raw_x_r, raw_x_nxt;
  logic signed [31:0] raw_y_r, raw_y_nxt;
  logic               seen_x_r, seen_x_nxt;
  logic               seen_y_r, seen_y_nxt;
  logic               armed_r, armed_nxt;
  logic               pkind_r, pkind_nxt;
  logic [11:0]        px_r, px_nxt;
  logic [11:0]        py_r, py_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic               okind_r, okind_nxt;
  logic [11:0]        ox_r, ox_nxt;
  logic [11:0]        oy_r, oy_nxt;
  logic               map_start;
  map_rsp_t           map_rsp;

  logic               acc;
  logic               req_type, from_touch;
  logic [15:0]        ev_type, ev_code;
  logic signed [31:0] ev_value;
  logic               is_btn;

  assign req_type   = in_tuser[0];
  assign from_touch = in_tuser[1];
  assign ev_type    = in_tdata[15:0];
  assign ev_code    = in_tdata[31:16];
  assign ev_value   = in_tdata[63:32];
  assign in_tready  = (state_r == T_IDLE);
  assign acc        = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign is_btn     = (ev_code == CODE_BTN_TOUCH) || (ev_code == CODE_BTN_TOOL_FINGER) ||
                      (ev_code == CODE_BTN_TOOL_PEN);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_data[12:0];
        CFG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_data[12:0];
        CFG_ORIENT:        cfg_nxt.orient        = cfg_data[2:0];
        CFG_X_MIN:         cfg_nxt.x_min         = cfg_data;
        CFG_X_MAX:         cfg_nxt.x_max         = cfg_data;
        CFG_Y_MIN:         cfg_nxt.y_min         = cfg_data;
        CFG_Y_MAX:         cfg_nxt.y_max         = cfg_data;
        default:           cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    raw_x_nxt  = raw_x_r;
    raw_y_nxt  = raw_y_r;
    seen_x_nxt = seen_x_r;
    seen_y_nxt = seen_y_r;
    armed_nxt  = armed_r;
    pkind_nxt  = pkind_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    ovalid_nxt = ovalid_r;
    okind_nxt  = okind_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    map_start  = 1'b0;

    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      T_IDLE: begin
        if (acc) begin
          priority if (req_type == REQ_REARM) begin
            armed_nxt = 1'b1;
          end else if (!from_touch) begin
            if (ev_type == EVT_KEY && ev_value == $signed({16'd0, KEY_DOWN}) &&
                ev_code != CODE_KEY_POWER) begin
              pkind_nxt = KIND_EXIT;
              px_nxt    = '0;
              py_nxt    = '0;
              state_nxt = T_HOLD;
            end
          end else if (ev_type == EVT_KEY) begin
            if (is_btn && ev_value == '0) begin
              armed_nxt = 1'b1;
            end
          end else if (ev_type == EVT_ABS) begin
            priority if (ev_code == CODE_MT_X || ev_code == CODE_ABS_X) begin
              raw_x_nxt  = ev_value;
              seen_x_nxt = 1'b1;
            end else if (ev_code == CODE_MT_Y || ev_code == CODE_ABS_Y) begin
              raw_y_nxt  = ev_value;
              seen_y_nxt = 1'b1;
            end else if (ev_code == CODE_MT_TRACK && ev_value[31]) begin
              armed_nxt = 1'b1;
            end else begin
              armed_nxt = armed_r;
            end
          end else if (ev_type == EVT_SYN && ev_code == CODE_SYN_REPORT) begin
            if (seen_x_r && seen_y_r && armed_r) begin
              armed_nxt = 1'b0;
              map_start = 1'b1;
              state_nxt = T_MAP;
            end
          end else begin
            armed_nxt = armed_r;
          end
        end
      end
      T_MAP: begin
        if (map_rsp.done) begin
          pkind_nxt = KIND_TAP;
          px_nxt    = map_rsp.x;
          py_nxt    = map_rsp.y;
          state_nxt = T_HOLD;
        end
      end
      T_HOLD: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = pkind_r;
          ox_nxt     = px_r;
          oy_nxt     = py_r;
          state_nxt  = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    pkind_r <= pkind_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    okind_r <= okind_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    if (!rst_n) begin
      state_r  <= T_IDLE;
      seen_x_r <= 1'b0;
      seen_y_r <= 1'b0;
      armed_r  <= 1'b1;
      ovalid_r <= 1'b0;
      raw_x_r  <= '0;
      raw_y_r  <= '0;
      cfg_r    <= '{screen_width: 13'd1024, screen_height: 13'd1024, orient: 3'd0,
                    x_min: '0, x_max: '0, y_min: '0, y_max: '0};
    end else begin
      state_r  <= state_nxt;
      seen_x_r <= seen_x_nxt;
      seen_y_r <= seen_y_nxt;
      armed_r  <= armed_nxt;
      ovalid_r <= ovalid_nxt;
      raw_x_r  <= raw_x_nxt;
      raw_y_r  <= raw_y_nxt;
      cfg_r    <= cfg_nxt;
    end
  end

  ttm_mapper u_map (
    .clk  (clk),
    .rst_n(rst_n),
    .start(map_start),
    .cfg  (cfg_r),
    .raw_x(raw_x_r),
    .raw_y(raw_y_r),
    .rsp  (map_rsp)
  );

  assign out_tvalid = ovalid_r;
  assign out_tuser  = okind_r;
  assign out_tdata  = {oy_r, ox_r};

endmodule

/* design/ttm_checker.sv */
// Port-level checks for touch_event_tap_mapper, bound to the top level.
// Depends on ttm_pkg.
module ttm_checker import ttm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output beat changed");

  a_exit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_EXIT |-> out_tdata == '0)
    else $error("exit-key beat carries coordinates");

  a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] == REQ_EVENT && !in_tuser[1] &&
    in_tdata[15:0] == EVT_KEY && in_tdata[63:32] == 32'd1 &&
    in_tdata[31:16] != CODE_KEY_POWER |=> !in_tready)
    else $error("exit-key beat did not stall input for its result");

  a_rearm_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] == REQ_REARM |=> in_tready)
    else $error("rearm beat blocked the input");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind touch_event_tap_mapper ttm_checker u_ttm_checker (.*);

/* test/touch_event_tap_mapper_tb.sv */
// Self-checking bench for touch_event_tap_mapper: event beats in, taps and exit keys out.
// A behavioral touch-state predictor fills a queue of expected results checked in order.
// Depends on ttm_pkg and the design top level.
module touch_event_tap_mapper_tb import ttm_pkg::*; ();

  localparam int CYCLE_LIMIT = 500_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic               req;
    logic [15:0]        etype;
    logic [15:0]        code;
    logic signed [31:0] val;
    logic               touch;
  } touch_event_t;

  typedef struct {
    logic        kind;
    logic [11:0] x;
    logic [11:0] y;
  } screen_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  touch_event_t   pending_events[$];
  screen_result_t expected_results[$];
  touch_event_t   tx_item;
  logic           tx_offering = 1'b0;
  int             tx_gap = 0;
  int             rx_stall = 0;
  int             tx_mode = 0;
  int             rx_mode = 0;
  logic           rx_hold_arm = 1'b0;
  int             rx_hold_left = 0;
  int             mismatch_count = 0;
  int             queued_events = 0;

  // predictor copy of registers and touch state
  logic [12:0] cfg_w = 13'd1024;
  logic [12:0] cfg_h = 13'd1024;
  logic [2:0]  cfg_orient = '0;
  longint      cfg_xl = 0;
  longint      cfg_xh = 0;
  longint      cfg_yl = 0;
  longint      cfg_yh = 0;
  longint      lat_x = 0;
  longint      lat_y = 0;
  bit          have_x = 1'b0;
  bit          have_y = 1'b0;
  bit          armed = 1'b1;

  touch_event_tap_mapper i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint usable_dim(input logic [12:0] d);
    if (d < 13'd1) return 1;
    if (d > 13'd4096) return 4096;
    return longint'(d);
  endfunction

  function automatic longint fit_coord(input longint v, input longint lo, input longint hi,
                                       input longint top);
    longint d;
    longint q;
    if (hi <= lo) return v;
    d = v - lo;
    if (d <= 0) return 0;
    q = (d * top) / (hi - lo);
    return (q > top) ? top : q;
  endfunction

  function automatic bit map_event(input touch_event_t ev, output screen_result_t res);
    longint v;
    longint sw;
    longint sh;
    longint w;
    longint h;
    longint longest;
    longint px;
    longint py;
    res = '{KIND_TAP, 12'd0, 12'd0};
    v = longint'($signed(ev.val));
    if (ev.req == REQ_REARM) begin
      armed = 1'b1;
      return 1'b0;
    end
    if (!ev.touch) begin
      if (ev.etype == EVT_KEY && v == 1 && ev.code != CODE_KEY_POWER) begin
        res.kind = KIND_EXIT;
        return 1'b1;
      end
      return 1'b0;
    end
    if (ev.etype == EVT_KEY) begin
      if ((ev.code == CODE_BTN_TOUCH || ev.code == CODE_BTN_TOOL_FINGER ||
           ev.code == CODE_BTN_TOOL_PEN) && v == 0) armed = 1'b1;
      return 1'b0;
    end
    if (ev.etype == EVT_ABS) begin
      if (ev.code == CODE_MT_X || ev.code == CODE_ABS_X) begin
        lat_x = v;
        have_x = 1'b1;
      end else if (ev.code == CODE_MT_Y || ev.code == CODE_ABS_Y) begin
        lat_y = v;
        have_y = 1'b1;
      end else if (ev.code == CODE_MT_TRACK && v < 0) begin
        armed = 1'b1;
      end
      return 1'b0;
    end
    if (ev.etype != EVT_SYN || ev.code != CODE_SYN_REPORT || !have_x || !have_y || !armed)
      return 1'b0;
    sw = usable_dim(cfg_w);
    sh = usable_dim(cfg_h);
    w = sw - 1;
    h = sh - 1;
    longest = ((sw > sh) ? sw : sh) + longint'(SCALE_MARGIN);
    if (cfg_xh - cfg_xl > longest || cfg_yh - cfg_yl > longest) begin
      if (cfg_orient[0]) begin
        px = fit_coord(lat_y, cfg_yl, cfg_yh, w);
        py = fit_coord(lat_x, cfg_xl, cfg_xh, h);
      end else begin
        px = fit_coord(lat_x, cfg_xl, cfg_xh, w);
        py = fit_coord(lat_y, cfg_yl, cfg_yh, h);
      end
    end else if (cfg_orient[0]) begin
      px = lat_y;
      py = lat_x;
    end else begin
      px = lat_x;
      py = lat_y;
    end
    if (cfg_orient[1]) px = w - px;
    if (cfg_orient[2]) py = h - py;
    if (px < 0) px = 0;
    if (py < 0) py = 0;
    if (px > w) px = w;
    if (py > h) py = h;
    armed = 1'b0;
    res.x = px[11:0];
    res.y = py[11:0];
    return 1'b1;
  endfunction

  function automatic int draw_wait(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 19);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // input side: offer pending beats, predict on acceptance
  always @(posedge clk) begin
    screen_result_t res;
    logic drive_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
      tx_offering = 1'b0;
    end else begin
      drive_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        if (map_event(tx_item, res)) expected_results.push_back(res);
        tx_gap = draw_wait(tx_mode);
        drive_valid = 1'b0;
        tx_offering = 1'b0;
      end
      if (!drive_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_events.size() > 0) begin
          tx_item = pending_events.pop_front();
          in_tdata <= {tx_item.val, tx_item.code, tx_item.etype};
          in_tuser <= {tx_item.touch, tx_item.req};
          drive_valid = 1'b1;
          tx_offering = 1'b1;
        end
      end
      in_tvalid <= drive_valid;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_left <= 0;
    end else if (rx_hold_arm) begin
      rx_hold_left <= HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // result side: check each beat against the oldest expectation
  always @(posedge clk) begin
    screen_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected kind=%0d x=%0d y=%0d",
                                    out_tuser, out_tdata[11:0], out_tdata[23:12]));
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch($sformatf("kind exp %0d got %0d", want.kind, out_tuser));
          if (out_tdata[11:0] !== want.x)
            report_mismatch($sformatf("tap_x exp %0d got %0d", want.x, out_tdata[11:0]));
          if (out_tdata[23:12] !== want.y)
            report_mismatch($sformatf("tap_y exp %0d got %0d", want.y, out_tdata[23:12]));
        end
        rx_stall = draw_wait(rx_mode);
      end else if (out_tvalid && rx_stall > 0) begin
        rx_stall--;
      end
      out_tready <= (rx_stall == 0) && (rx_hold_left == 0);
    end
  end

  task automatic add_event(input logic req, input logic [15:0] etype, input logic [15:0] code,
                           input logic [31:0] val, input logic touch);
    touch_event_t ev;
    ev.req = req;
    ev.etype = etype;
    ev.code = code;
    ev.val = val;
    ev.touch = touch;
    pending_events.push_back(ev);
    queued_events++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SCREEN_WIDTH:  cfg_w = val[12:0];
      CFG_SCREEN_HEIGHT: cfg_h = val[12:0];
      CFG_ORIENT:        cfg_orient = val[2:0];
      CFG_X_MIN:         cfg_xl = longint'($signed(val));
      CFG_X_MAX:         cfg_xh = longint'($signed(val));
      CFG_Y_MIN:         cfg_yl = longint'($signed(val));
      CFG_Y_MAX:         cfg_yh = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic apply_setup(input logic [31:0] w, input logic [31:0] h, input logic [31:0] f,
                             input logic [31:0] xl, input logic [31:0] xh,
                             input logic [31:0] yl, input logic [31:0] yh);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    write_reg(CFG_ORIENT, f);
    write_reg(CFG_X_MIN, xl);
    write_reg(CFG_X_MAX, xh);
    write_reg(CFG_Y_MIN, yl);
    write_reg(CFG_Y_MAX, yh);
  endtask

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd4096;
      3: return 32'd8191;
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  function automatic void pick_range(output logic [31:0] lo, output logic [31:0] hi);
    case ($urandom_range(0, 3))
      0: begin
        lo = $urandom;
        hi = $urandom;
      end
      1: begin
        lo = $urandom_range(0, 300);
        hi = lo + $urandom_range(0, 20000);
      end
      2: begin
        lo = 32'h8000_0000 | $urandom_range(0, 50);
        hi = $urandom_range(0, 50);
      end
      default: begin
        lo = $urandom_range(0, 4000);
        hi = lo;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_coord(input longint lo, input longint hi);
    longint span;
    span = hi - lo;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'(lo);
      2: return 32'(hi);
      3: return 32'(lo - 1);
      4: return 32'(hi + 1);
      default: begin
        if (span > 0) return 32'(lo + longint'({$urandom, $urandom} % 64'(span + 1)));
        return 32'(longint'($urandom_range(0, 5000)) - 100);
      end
    endcase
  endfunction

  task automatic queue_gesture();
    logic [15:0] xc;
    logic [15:0] yc;
    xc = $urandom_range(0, 1) ? CODE_MT_X : CODE_ABS_X;
    yc = $urandom_range(0, 1) ? CODE_MT_Y : CODE_ABS_Y;
    if ($urandom_range(0, 1))
      add_event(REQ_EVENT, EVT_ABS, CODE_MT_TRACK, $urandom_range(0, 2000), 1'b1);
    if ($urandom_range(0, 3) == 0)
      add_event(REQ_EVENT, EVT_KEY, CODE_BTN_TOUCH, 32'd1, 1'b1);
    if ($urandom_range(0, 1)) begin
      add_event(REQ_EVENT, EVT_ABS, xc, pick_coord(cfg_xl, cfg_xh), 1'b1);
      add_event(REQ_EVENT, EVT_ABS, yc, pick_coord(cfg_yl, cfg_yh), 1'b1);
    end else begin
      add_event(REQ_EVENT, EVT_ABS, yc, pick_coord(cfg_yl, cfg_yh), 1'b1);
      add_event(REQ_EVENT, EVT_ABS, xc, pick_coord(cfg_xl, cfg_xh), 1'b1);
    end
    if ($urandom_range(0, 3) == 0)
      add_event(REQ_EVENT, EVT_ABS, xc, pick_coord(cfg_xl, cfg_xh), 1'b1);
    add_event(REQ_EVENT, EVT_SYN, CODE_SYN_REPORT, $urandom, 1'b1);
    if ($urandom_range(0, 3) == 0)
      add_event(REQ_EVENT, EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b1);
    case ($urandom_range(0, 5))
      0: add_event(REQ_EVENT, EVT_KEY, CODE_BTN_TOUCH, 32'd0, 1'b1);
      1: add_event(REQ_EVENT, EVT_KEY, CODE_BTN_TOOL_FINGER, 32'd0, 1'b1);
      2: add_event(REQ_EVENT, EVT_KEY, CODE_BTN_TOOL_PEN, 32'd0, 1'b1);
      3: add_event(REQ_EVENT, EVT_ABS, CODE_MT_TRACK, 32'h8000_0000 | $urandom, 1'b1);
      4: add_event(REQ_REARM, 16'($urandom), 16'($urandom), $urandom, $urandom_range(0, 1));
      default: ;
    endcase
  endtask

  task automatic queue_random(input int target);
    int start;
    logic [15:0] etype;
    logic [15:0] code;
    start = queued_events;
    while (queued_events - start < target) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0: etype = EVT_SYN;
            1: etype = EVT_KEY;
            2: etype = EVT_ABS;
            default: etype = 16'($urandom);
          endcase
          code = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
          add_event($urandom_range(0, 7) == 0, etype, code, $urandom, $urandom_range(0, 1));
        end
        1: begin
          code = ($urandom_range(0, 3) == 0) ? CODE_KEY_POWER : 16'($urandom);
          add_event(REQ_EVENT, EVT_KEY, code,
                    ($urandom_range(0, 2) == 0) ? $urandom : 32'd1, 1'b0);
        end
        default: queue_gesture();
      endcase
    end
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || tx_offering || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("touch_event_tap_mapper regression: fail");
    $finish;
  end

  initial begin
    logic [31:0] xl;
    logic [31:0] xh;
    logic [31:0] yl;
    logic [31:0] yh;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset setup, raw coordinates pass unscaled
    add_event(REQ_EVENT, EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b1);
    add_event(REQ_EVENT, EVT_KEY, 16'd30, 32'd1, 1'b0);
    add_event(REQ_EVENT, EVT_KEY, CODE_KEY_POWER, 32'd1, 1'b0);
    add_event(REQ_EVENT, EVT_KEY, 16'hffff, 32'd0, 1'b0);
    add_event(REQ_EVENT, EVT_KEY, 16'd30, 32'd1, 1'b1);
    add_event(REQ_EVENT, EVT_ABS, CODE_ABS_X, 32'h7fff_ffff, 1'b1);
    add_event(REQ_EVENT, EVT_ABS, CODE_ABS_Y, 32'h8000_0000, 1'b1);
    add_event(REQ_EVENT, EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b1);
    add_event(REQ_EVENT, EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b1);
    add_event(REQ_REARM, 16'hffff, 16'hffff, 32'hffff_ffff, 1'b1);
    add_event(REQ_EVENT, EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b1);
    add_event(REQ_EVENT, EVT_KEY, CODE_BTN_TOUCH, 32'd0, 1'b1);
    add_event(REQ_EVENT, EVT_ABS, CODE_MT_X, 32'd5, 1'b1);
    add_event(REQ_EVENT, EVT_ABS, CODE_MT_Y, 32'd7, 1'b1);
    add_event(REQ_EVENT, EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b1);
    add_event(REQ_EVENT, EVT_KEY, CODE_BTN_TOOL_FINGER, 32'd0, 1'b1);
    add_event(REQ_EVENT, EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b1);
    add_event(REQ_EVENT, EVT_KEY, CODE_BTN_TOOL_PEN, 32'd0, 1'b1);
    add_event(REQ_EVENT, EVT_ABS, CODE_MT_TRACK, 32'd3, 1'b1);
    add_event(REQ_EVENT, EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b1);
    add_event(REQ_EVENT, EVT_ABS, CODE_MT_TRACK, 32'hffff_ffff, 1'b1);
    add_event(REQ_EVENT, 16'hffff, 16'hffff, 32'hffff_ffff, 1'b1);
    add_event(REQ_EVENT, EVT_SYN, 16'd2, 32'd0, 1'b1);
    add_event(REQ_EVENT, EVT_ABS, 16'hffff, 32'd0, 1'b1);
    add_event(REQ_EVENT, EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b1);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setup(1024, 768, 0, 0, 4095, 0, 4095);
        1: apply_setup(0, 0, 7, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        2: apply_setup(4096, 8191, 5, 32'h8000_0000, 32'h7fff_ffff, 100, 100);
        3: apply_setup(600, 800, 3, -432, 432, 0, 864);
        4: apply_setup(600, 800, 6, -432, 433, 10, 10);
        default: begin
          pick_range(xl, xh);
          pick_range(yl, yh);
          apply_setup(pick_dim(), pick_dim(), $urandom_range(0, 7), xl, xh, yl, yh);
        end
      endcase
      tx_mode = (p == 0) ? 1 : $urandom_range(0, 2);
      rx_mode = (p == 0) ? 1 : $urandom_range(0, 2);
      if (p == 5) begin
        // output held off while exit keys stream in back to back
        tx_mode = 0;
        rx_hold_arm <= 1'b1;
        @(posedge clk);
        rx_hold_arm <= 1'b0;
        repeat (30) add_event(REQ_EVENT, EVT_KEY, 16'($urandom_range(0, 115)), 32'd1, 1'b0);
      end
      queue_random(60);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("touch_event_tap_mapper regression: pass");
    end else begin
      $display("touch_event_tap_mapper regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ttm_pkg.sv
design/ttm_divider.sv
design/ttm_mapper.sv
design/touch_event_tap_mapper.sv
design/ttm_checker.sv
test/touch_event_tap_mapper_tb.sv
